// ----- rtl/core/dshenc_pkg.sv -----
`default_nettype none

package dshenc_pkg;

  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned CMP_W     = 16;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned PORT_CH   = 4;
  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned DATA_BITS = 11;

  // Register indexes on the configuration port
  localparam logic REG_ZERO_CMP = 1'b0;
  localparam logic REG_ONE_CMP  = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value_ch0;
    logic [VALUE_W-1:0] value_ch1;
    logic [VALUE_W-1:0] value_ch2;
    logic [VALUE_W-1:0] value_ch3;
    logic [MASK_W-1:0]  telemetry_mask;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_number;
    logic [CMP_W-1:0]  compare_ch0;
    logic [CMP_W-1:0]  compare_ch1;
    logic [CMP_W-1:0]  compare_ch2;
    logic [CMP_W-1:0]  compare_ch3;
    logic              last_slot;
    logic              bad_value;
  } out_beat_t;

  // 11-bit value, telemetry bit, then XOR-nibble checksum
  function automatic logic [FRAME_BITS-1:0] make_packet(input logic [DATA_BITS-1:0] value,
                                                         input logic telem);
    logic [11:0] payload;
    logic [3:0]  csum;
    payload = {value, telem};
    csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
    return {payload, csum};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dshenc_cell.sv -----
`default_nettype none

module dshenc_cell #(
  parameter int unsigned WIDTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic             shift_i,
  input  wire logic [WIDTH-1:0] load_bits_i,
  input  wire logic [WIDTH-1:0] next_bits_i,
  output logic      [WIDTH-1:0] bits_o
);

  logic [WIDTH-1:0] bits_q, bits_d;

  // Take a fresh packet bit, or the neighbour's bit as the frame moves on
  always_comb begin
    bits_d = bits_q;
    if (load_i) begin
      bits_d = load_bits_i;
    end else if (shift_i) begin
      bits_d = next_bits_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

  assign bits_o = bits_q;

endmodule

`default_nettype wire

// ----- rtl/core/dshot_multichannel_frame_encoder_unit.sv -----
`default_nettype none

// DShot frame encoder for up to four motor channels. Each input beat carries
// one throttle/command value per channel and a telemetry mask; it yields
// 16 bit slots (MSB first, one_compare for a 1, zero_compare for a 0) and then
// GAP_SLOT_COUNT gap slots with all compares zero, the final slot flagged
// last_slot. If any active channel value exceeds 2047 a single beat with
// bad_value and last_slot set and all compares zero is sent instead. Rate:
// one output beat per cycle while out_ready_i is high; a frame is 16 +
// GAP_SLOT_COUNT beats (18 by default), a rejected one a single beat; the
// single output register fed by the row of bit cells sets this. One further
// input beat is buffered during a frame, so frames follow with no idle slot.
// Configuration: zero_compare at byte address 0, one_compare at address 4,
// both 16 bits (reset 150 and 300); write only while the block is idle.

module dshot_multichannel_frame_encoder_unit #(
  parameter int unsigned CHANNELS       = 4,
  parameter int unsigned GAP_SLOT_COUNT = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire dshenc_pkg::in_beat_t in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output dshenc_pkg::out_beat_t     out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  import dshenc_pkg::*;

  localparam int unsigned TOTAL = FRAME_BITS + GAP_SLOT_COUNT;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TOTAL - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] zero_cmp_q, zero_cmp_d;
  logic [CMP_W-1:0] one_cmp_q, one_cmp_d;
  logic             cfg_wr;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_comb begin
    zero_cmp_d = zero_cmp_q;
    one_cmp_d  = one_cmp_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_ZERO_CMP: zero_cmp_d = pwdata[CMP_W-1:0];
        REG_ONE_CMP:  one_cmp_d  = pwdata[CMP_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ZERO_CMP: prdata = {{(32-CMP_W){1'b0}}, zero_cmp_q};
      REG_ONE_CMP:  prdata = {{(32-CMP_W){1'b0}}, one_cmp_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input buffer: packets are built as the beat is accepted
  // ---------------------------------------------------------------------
  logic [PORT_CH-1:0][VALUE_W-1:0]  in_vals;
  logic [CHANNELS-1:0][FRAME_BITS-1:0] pkt_d;
  logic [CHANNELS-1:0][FRAME_BITS-1:0] buf_pkt_q;
  logic                                in_bad;
  logic                                buf_bad_q;
  logic                                buf_valid_q, buf_valid_d;
  logic                                in_acc;

  assign in_vals = {in_data_i.value_ch3, in_data_i.value_ch2,
                    in_data_i.value_ch1, in_data_i.value_ch0};

  always_comb begin
    in_bad = 1'b0;
    for (int unsigned c = 0; c < CHANNELS; c++) begin
      pkt_d[c] = make_packet(in_vals[c][DATA_BITS-1:0], in_data_i.telemetry_mask[c]);
      if (in_vals[c][VALUE_W-1:DATA_BITS] != '0) begin
        in_bad = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Frame sequencer
  // ---------------------------------------------------------------------
  logic              busy_q, busy_d;
  logic              bad_q, bad_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              advance;
  logic              is_last;
  logic              done;
  logic              load;

  assign advance    = busy_q && (!out_valid_o || out_ready_i);
  assign is_last    = bad_q || (slot_q == LAST_IDX);
  assign done       = advance && is_last;
  assign load       = buf_valid_q && (!busy_q || done);
  assign in_ready_o = !buf_valid_q || load;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    buf_valid_d = buf_valid_q;
    if (in_acc) begin
      buf_valid_d = 1'b1;
    end else if (load) begin
      buf_valid_d = 1'b0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    bad_d  = bad_q;
    slot_d = slot_q;
    if (load) begin
      busy_d = 1'b1;
      bad_d  = buf_bad_q;
      slot_d = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (advance) begin
      slot_d = slot_q + SLOT_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Row of bit cells: cell 0 holds the bit now on the wire for every
  // channel; each advance shifts the row one cell towards cell 0.
  // ---------------------------------------------------------------------
  logic [FRAME_BITS-1:0][CHANNELS-1:0] cell_load;
  logic [FRAME_BITS-1:0][CHANNELS-1:0] cell_bits;
  logic [FRAME_BITS-1:0][CHANNELS-1:0] cell_next;

  always_comb begin
    for (int unsigned b = 0; b < FRAME_BITS; b++) begin
      for (int unsigned c = 0; c < CHANNELS; c++) begin
        cell_load[b][c] = buf_pkt_q[c][FRAME_BITS-1-b];
      end
      cell_next[b] = (b == FRAME_BITS - 1) ? '0 : cell_bits[(b + 1) % FRAME_BITS];
    end
  end

  for (genvar b = 0; b < FRAME_BITS; b++) begin : g_cell
    dshenc_cell #(
      .WIDTH(CHANNELS)
    ) u_cell (
      .clk_i      (clk_i),
      .load_i     (load),
      .shift_i    (advance),
      .load_bits_i(cell_load[b]),
      .next_bits_i(cell_next[b]),
      .bits_o     (cell_bits[b])
    );
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic                            out_valid_q, out_valid_d;
  out_beat_t                       out_q, out_d;
  logic [PORT_CH-1:0][CMP_W-1:0]   cmp;
  logic                            in_frame;

  assign in_frame = slot_q < SLOT_W'(FRAME_BITS);

  always_comb begin
    cmp = '0;
    for (int unsigned c = 0; c < CHANNELS; c++) begin
      if (in_frame && !bad_q) begin
        cmp[c] = cell_bits[0][c] ? one_cmp_q : zero_cmp_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d       = 1'b1;
      out_d.slot_number = bad_q ? '0 : slot_q;
      out_d.compare_ch0 = cmp[0];
      out_d.compare_ch1 = cmp[1];
      out_d.compare_ch2 = cmp[2];
      out_d.compare_ch3 = cmp[3];
      out_d.last_slot   = is_last;
      out_d.bad_value   = bad_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_cmp_q  <= CMP_W'(150);
      one_cmp_q   <= CMP_W'(300);
      buf_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      bad_q       <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      zero_cmp_q  <= zero_cmp_d;
      one_cmp_q   <= one_cmp_d;
      buf_valid_q <= buf_valid_d;
      busy_q      <= busy_d;
      bad_q       <= bad_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold unless a new beat lands
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_pkt_q <= pkt_d;
      buf_bad_q <= in_bad;
    end
    out_q <= out_d;
  end

endmodule

`default_nettype wire
